// ===== rtl/arsdp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package arsdp_pkg;

    localparam int unsigned CNT_W = 21;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [31:0] HDR_LEN = 32'd36;
    localparam logic [32:0] MAX_TABLE_BYTES = 33'd1048576;

    localparam logic MODE_RSDP = 1'b0;
    localparam logic MODE_ROOT = 1'b1;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_RSDT = 2'd1;
    localparam logic [1:0] KIND_XSDT = 2'd2;

    localparam logic [7:0] RSDP_SIG [0:7] = '{"R", "S", "D", " ", "P", "T", "R", " "};
    localparam logic [7:0] RSDT_SIG [0:3] = '{"R", "S", "D", "T"};
    localparam logic [7:0] XSDT_SIG [0:3] = '{"X", "S", "D", "T"};

    typedef struct packed {
        logic [7:0] data_byte;
        logic       mode;
        logic       last;
    } in_t;

    typedef struct packed {
        logic        structure;
        logic        valid_res;
        logic [1:0]  table_kind;
        logic [63:0] root_address;
        logic [20:0] table_bytes;
        logic [17:0] entry_total;
    } out_t;

endpackage

`default_nettype wire

// ===== rtl/acpi_rsdp_root_table_checker_core.sv =====
// A verdict appears in the result register in the cycle after its last byte is taken.
// Throughput: one byte per cycle; a byte is taken while a verdict waits, as long as the
// result register frees up in the same cycle (in_ready = !out_valid || out_ready).
// Per-byte field capture and the 8-bit running sum set the combinational update path.
// Reset (rst_n low, asynchronous): counters and sums clear, root table disarmed, no result.
`timescale 1ns / 1ps
`default_nettype none

module acpi_rsdp_root_table_checker_core
    import arsdp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire in_t  in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output out_t      out_data
);

    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [7:0]       running_sum_reg, running_sum_next;
    logic             signature_ok_reg, signature_ok_next;
    logic [7:0]       revision_reg, revision_next;
    logic [31:0]      length_field_reg, length_field_next;
    logic             base_sum_ok_reg, base_sum_ok_next;
    logic             full_sum_ok_reg, full_sum_ok_next;
    logic [31:0]      short_address_reg, short_address_next;
    logic [63:0]      long_address_reg, long_address_next;
    logic             rsdp_ok_reg, rsdp_ok_next;
    logic [1:0]       chosen_kind_reg, chosen_kind_next;
    logic             out_valid_reg;
    out_t             out_data_reg, result;

    logic             accept;
    logic [CNT_W-1:0] p;
    logic [CNT_W-1:0] n;
    logic [7:0]       b;
    logic [7:0]       sum_add;
    logic [7:0]       root_sig_byte;
    logic             rsdp_ok_v;
    logic [1:0]       rsdp_kind;
    logic [63:0]      rsdp_addr;
    logic             root_ok;
    logic [31:0]      len_body;
    logic             len_aligned;
    logic [31:0]      entries;
    logic [63:0]      root_addr;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign p       = byte_count_reg;
    assign b       = in_data.data_byte;
    assign sum_add = running_sum_reg + b;
    assign root_sig_byte = (chosen_kind_reg == KIND_XSDT) ? XSDT_SIG[p[1:0]]
                                                          : RSDT_SIG[p[1:0]];

    // per-byte state update
    always_comb
    begin
        running_sum_next   = running_sum_reg;
        signature_ok_next  = signature_ok_reg;
        revision_next      = revision_reg;
        length_field_next  = length_field_reg;
        base_sum_ok_next   = base_sum_ok_reg;
        full_sum_ok_next   = full_sum_ok_reg;
        short_address_next = short_address_reg;
        long_address_next  = long_address_reg;
        rsdp_ok_next       = rsdp_ok_reg;
        chosen_kind_next   = chosen_kind_reg;

        if (in_data.mode == MODE_RSDP)
        begin
            if (p == '0)
            begin
                rsdp_ok_next     = 1'b0;
                chosen_kind_next = KIND_NONE;
            end
            if (p < CNT_W'(8) && b != RSDP_SIG[p[2:0]])
                signature_ok_next = 1'b0;
            if (p < CNT_W'(36))
                running_sum_next = sum_add;
            if (p == CNT_W'(15))
                revision_next = b;
            if (p >= CNT_W'(16) && p < CNT_W'(20))
                short_address_next[{p[1:0], 3'b000} +: 8] = b;
            if (p >= CNT_W'(20) && p < CNT_W'(24))
                length_field_next[{p[1:0], 3'b000} +: 8] = b;
            if (p >= CNT_W'(24) && p < CNT_W'(32))
                long_address_next[{p[2:0], 3'b000} +: 8] = b;
            if (p == CNT_W'(19))
                base_sum_ok_next = (running_sum_next == 8'd0);
            if (p == CNT_W'(35))
                full_sum_ok_next = (running_sum_next == 8'd0);
        end
        else
        begin
            if (p < CNT_W'(4) && b != root_sig_byte)
                signature_ok_next = 1'b0;
            if (p >= CNT_W'(4) && p < CNT_W'(8))
                length_field_next[{p[1:0], 3'b000} +: 8] = b;
            if (p < CNT_W'(8) || {11'd0, p} < length_field_next)
                running_sum_next = sum_add;
        end

        byte_count_next = (p < COUNT_MAX) ? p + CNT_W'(1) : p;
    end

    assign n = byte_count_next;

    // RSDP verdict
    always_comb
    begin
        rsdp_ok_v = signature_ok_next && n >= CNT_W'(20) && base_sum_ok_next &&
                    (revision_next < 8'd2 ||
                     (n >= CNT_W'(36) && length_field_next == HDR_LEN && full_sum_ok_next));
        if (revision_next >= 8'd2 && long_address_next != 64'd0)
        begin
            rsdp_kind = KIND_XSDT;
            rsdp_addr = long_address_next;
        end
        else
        begin
            rsdp_kind = KIND_RSDT;
            rsdp_addr = {32'd0, short_address_next};
        end
        if (!rsdp_ok_v || rsdp_addr == 64'd0)
        begin
            rsdp_kind = KIND_NONE;
            rsdp_addr = 64'd0;
        end
    end

    // root table verdict; entry width 4 or 8, so alignment and count are mask and shift
    assign len_body    = length_field_next - HDR_LEN;
    assign len_aligned = (chosen_kind_reg == KIND_XSDT) ? (len_body[2:0] == 3'd0)
                                                        : (len_body[1:0] == 2'd0);
    assign entries     = (chosen_kind_reg == KIND_XSDT) ? (len_body >> 3) : (len_body >> 2);
    assign root_addr   = (chosen_kind_reg == KIND_XSDT) ? long_address_reg
                                                        : {32'd0, short_address_reg};
    assign root_ok = rsdp_ok_reg && chosen_kind_reg != KIND_NONE && signature_ok_next &&
                     n >= CNT_W'(8) && length_field_next >= HDR_LEN &&
                     {1'b0, length_field_next} <= MAX_TABLE_BYTES && len_aligned &&
                     {11'd0, n} >= length_field_next && running_sum_next == 8'd0;

    always_comb
    begin
        result = '0;
        result.structure = in_data.mode;
        if (in_data.mode == MODE_RSDP)
        begin
            result.valid_res    = rsdp_ok_v;
            result.table_kind   = rsdp_kind;
            result.root_address = rsdp_addr;
        end
        else if (root_ok)
        begin
            result.valid_res    = 1'b1;
            result.table_kind   = chosen_kind_reg;
            result.root_address = root_addr;
            result.table_bytes  = length_field_next[20:0];
            result.entry_total  = entries[17:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg    <= '0;
            running_sum_reg   <= '0;
            signature_ok_reg  <= 1'b1;
            revision_reg      <= '0;
            length_field_reg  <= '0;
            base_sum_ok_reg   <= 1'b0;
            full_sum_ok_reg   <= 1'b0;
            short_address_reg <= '0;
            long_address_reg  <= '0;
            rsdp_ok_reg       <= 1'b0;
            chosen_kind_reg   <= KIND_NONE;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (accept)
            begin
                short_address_reg <= short_address_next;
                long_address_reg  <= long_address_next;
                if (in_data.last)
                begin
                    // close the structure: clear per-structure state, arm or keep root
                    byte_count_reg   <= '0;
                    running_sum_reg  <= '0;
                    signature_ok_reg <= 1'b1;
                    revision_reg     <= '0;
                    length_field_reg <= '0;
                    base_sum_ok_reg  <= 1'b0;
                    full_sum_ok_reg  <= 1'b0;
                    if (in_data.mode == MODE_RSDP)
                    begin
                        rsdp_ok_reg     <= (rsdp_kind != KIND_NONE);
                        chosen_kind_reg <= rsdp_kind;
                    end
                    else
                    begin
                        rsdp_ok_reg     <= rsdp_ok_next;
                        chosen_kind_reg <= chosen_kind_next;
                    end
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    byte_count_reg   <= byte_count_next;
                    running_sum_reg  <= running_sum_next;
                    signature_ok_reg <= signature_ok_next;
                    revision_reg     <= revision_next;
                    length_field_reg <= length_field_next;
                    base_sum_ok_reg  <= base_sum_ok_next;
                    full_sum_ok_reg  <= full_sum_ok_next;
                    rsdp_ok_reg      <= rsdp_ok_next;
                    chosen_kind_reg  <= chosen_kind_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_data.last)
            out_data_reg <= result;
    end

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.last) |=> (out_valid_reg && byte_count_reg == '0))
        else $error("last byte did not produce a result or clear the count");

    a_armed_has_kind: assert property (@(posedge clk) disable iff (!rst_n)
        rsdp_ok_reg |-> (chosen_kind_reg == KIND_RSDT || chosen_kind_reg == KIND_XSDT))
        else $error("root table armed without a kind");

    a_invalid_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.valid_res) |->
        (out_data_reg.table_kind == KIND_NONE && out_data_reg.root_address == 64'd0 &&
         out_data_reg.table_bytes == 21'd0 && out_data_reg.entry_total == 18'd0))
        else $error("invalid verdict carries data");

    a_rsdp_no_size: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.structure == MODE_RSDP) |->
        (out_data_reg.table_bytes == 21'd0 && out_data_reg.entry_total == 18'd0))
        else $error("RSDP verdict carries a table size");

    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !in_ready)
        else $error("request taken while result register is blocked");

endmodule

`default_nettype wire
